// File: sv/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge of clk, off during reset.
`define ASSERT_HOLDS(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on the rising edge of clk, off during reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/smp_pkg.sv
// Shared types, MIDI codes and lookup function of the MIDI packetizer.
package smp_pkg;

    localparam logic [7:0] STATUS_BIT    = 8'h80;
    localparam logic [7:0] SYSEX_START   = 8'hF0;
    localparam logic [7:0] QUARTER_FRAME = 8'hF1;
    localparam logic [7:0] SONG_POS      = 8'hF2;
    localparam logic [7:0] SONG_SELECT   = 8'hF3;
    localparam logic [7:0] TUNE_REQUEST  = 8'hF6;
    localparam logic [7:0] SYSEX_END     = 8'hF7;

    localparam logic [3:0] CIN_COMMON_TWO   = 4'h2;
    localparam logic [3:0] CIN_COMMON_THREE = 4'h3;
    localparam logic [3:0] CIN_SYSEX        = 4'h4;
    localparam logic [3:0] CIN_SINGLE       = 4'h5;
    localparam logic [3:0] CIN_END_TWO      = 4'h6;
    localparam logic [3:0] CIN_END_THREE    = 4'h7;
    localparam logic [3:0] CIN_CHANNEL_LOW  = 4'h8;
    localparam logic [3:0] CIN_CHANNEL_HIGH = 4'hE;

    typedef struct packed {
        logic [3:0] code_index;
        logic [7:0] first_data;
        logic [7:0] second_data;
        logic [7:0] third_data;
    } pkt_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } byte_item_t;

    typedef struct packed {
        logic valid;
        pkt_t pkt;
    } pkt_item_t;

    // Data bytes that complete a channel message, by status high nibble.
    function automatic logic [1:0] data_len(input logic [3:0] kind);
        logic [1:0] len;
        case (kind)
            4'h8, 4'h9, 4'hA, 4'hB, 4'hE: len = 2'd2;
            4'hC, 4'hD:                   len = 2'd1;
            default:                      len = 2'd0;
        endcase
        return len;
    endfunction

endpackage

// File: sv/smp_in_reg.sv
// Input register that holds one received MIDI byte for the parser.
module smp_in_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_ready,
    input  logic [7:0]         serial_byte,
    input  logic               take,
    output smp_pkg::byte_item_t item
);
    import smp_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    // Refill whenever the held byte is empty or leaves this cycle.
    assign byte_ready = !valid_reg || take;
    assign valid_next = byte_valid || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (byte_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            data_reg <= serial_byte;
        end
    end

    assign item.valid = valid_reg;
    assign item.data  = data_reg;

endmodule

// File: sv/smp_parser.sv
// Message state and single-pass decode of one MIDI byte into a packet.
module smp_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  smp_pkg::byte_item_t item,
    input  logic               out_space,
    output logic               take,
    output smp_pkg::pkt_item_t  result
);
    import smp_pkg::*;

    typedef struct packed {
        logic [7:0] status;
        logic [1:0] gathered;
        logic [1:0] expected;
        logic [3:0] cin;
        logic [7:0] first;
        logic [7:0] second;
        logic [7:0] third;
    } msg_t;

    msg_t       msg_reg;
    msg_t       msg_next;
    logic       emit;
    pkt_t       pkt;
    logic [7:0] b;
    logic [3:0] kind;
    logic [1:0] gathered_inc;
    logic [7:0] second_upd;
    logic [7:0] third_upd;

    assign b            = item.data;
    assign kind         = b[7:4];
    assign gathered_inc = msg_reg.gathered + 2'd1;
    assign second_upd   = (msg_reg.gathered == 2'd0) ? b : msg_reg.second;
    assign third_upd    = (msg_reg.gathered == 2'd0) ? msg_reg.third : b;

    always_comb
    begin
        msg_next = msg_reg;
        emit     = 1'b0;
        pkt      = '0;
        if ((b & STATUS_BIT) != 8'h00)
        begin
            if (b == SYSEX_START)
            begin
                msg_next = '{SYSEX_START, 2'd1, 2'd3, CIN_SYSEX, SYSEX_START, 8'h00, 8'h00};
            end
            else if (b == SYSEX_END)
            begin
                msg_next = '0;
                emit     = 1'b1;
                if (msg_reg.status != SYSEX_START || msg_reg.gathered == 2'd0)
                begin
                    pkt = '{CIN_SINGLE, SYSEX_END, 8'h00, 8'h00};
                end
                else if (msg_reg.gathered == 2'd1)
                begin
                    pkt = '{CIN_END_TWO, msg_reg.first, SYSEX_END, 8'h00};
                end
                else
                begin
                    pkt = '{CIN_END_THREE, msg_reg.first, msg_reg.second, SYSEX_END};
                end
            end
            else if (b >= TUNE_REQUEST)
            begin
                msg_next = '0;
                emit     = 1'b1;
                pkt      = '{CIN_SINGLE, b, 8'h00, 8'h00};
            end
            else if (b == SONG_SELECT || b == QUARTER_FRAME)
            begin
                msg_next = '{b, 2'd0, 2'd1, CIN_COMMON_TWO, b, 8'h00, 8'h00};
            end
            else if (b == SONG_POS)
            begin
                msg_next = '{b, 2'd0, 2'd2, CIN_COMMON_THREE, b, 8'h00, 8'h00};
            end
            else if (b > SONG_SELECT)
            begin
                // undefined system common: drop and clear
                msg_next = '0;
            end
            else
            begin
                msg_next = '{{4'h0, kind}, 2'd0, data_len(kind), kind, b, 8'h00, 8'h00};
            end
        end
        else if (msg_reg.status == 8'h00)
        begin
            // data byte with no status: drop
            msg_next = msg_reg;
        end
        else if (msg_reg.status == SYSEX_START)
        begin
            if (msg_reg.gathered == 2'd0)
            begin
                msg_next.first    = b;
                msg_next.gathered = 2'd1;
            end
            else if (msg_reg.gathered == 2'd1)
            begin
                msg_next.second   = b;
                msg_next.gathered = 2'd2;
            end
            else
            begin
                emit              = 1'b1;
                pkt               = '{CIN_SYSEX, msg_reg.first, msg_reg.second, b};
                msg_next.first    = 8'h00;
                msg_next.second   = 8'h00;
                msg_next.third    = 8'h00;
                msg_next.gathered = 2'd0;
            end
        end
        else if (gathered_inc >= msg_reg.expected)
        begin
            emit              = 1'b1;
            pkt               = '{msg_reg.cin, msg_reg.first, second_upd, third_upd};
            msg_next.second   = 8'h00;
            msg_next.third    = 8'h00;
            msg_next.gathered = 2'd0;
            // system common ends its own running status
            if (msg_reg.status >= QUARTER_FRAME)
            begin
                msg_next = '0;
            end
        end
        else
        begin
            msg_next.second   = second_upd;
            msg_next.third    = third_upd;
            msg_next.gathered = gathered_inc;
        end
    end

    // Advance only when a resulting packet has room downstream.
    assign take         = item.valid && (!emit || out_space);
    assign result.valid = take && emit;
    assign result.pkt   = pkt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_reg <= '0;
        end
        else if (take)
        begin
            msg_reg <= msg_next;
        end
    end

endmodule

// File: sv/smp_out_reg.sv
// Output register that holds one finished event packet until transfer.
module smp_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  smp_pkg::pkt_item_t result,
    output logic              out_space,
    output logic              packet_valid,
    input  logic              packet_ready,
    output logic [3:0]        code_index,
    output logic [7:0]        first_data,
    output logic [7:0]        second_data,
    output logic [7:0]        third_data
);
    import smp_pkg::*;

    logic valid_reg;
    pkt_t pkt_reg;

    assign out_space = !valid_reg || packet_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_space)
        begin
            valid_reg <= result.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_space && result.valid)
        begin
            pkt_reg <= result.pkt;
        end
    end

    assign packet_valid = valid_reg;
    assign code_index   = pkt_reg.code_index;
    assign first_data   = pkt_reg.first_data;
    assign second_data  = pkt_reg.second_data;
    assign third_data   = pkt_reg.third_data;

endmodule

// File: sv/serial_midi_to_usb_midi_packetizer.sv
// Top level of the serial MIDI byte stream to USB-MIDI event packetizer.
//
// Input channel: byte_valid / byte_ready carry one serial MIDI byte per
// transfer on serial_byte. Output channel: packet_valid / packet_ready
// carry one USB-MIDI event packet per transfer: code_index (cable zero)
// and first_data, second_data, third_data, unused bytes zero.
// A byte transfer lands in an input register; in the next cycle the
// parser decodes it against the held message state and, if it completes
// a message, SysEx chunk or single-byte event, loads the output register.
// Throughput: one byte per cycle unless a completing byte finds the output
// register full; the decode between the input and output registers is
// combinational.
// Bytes that complete nothing pass through even while a packet waits.
// When the receiver stalls, the waiting packet holds; a completing byte
// then holds in the parser's input register and byte_ready drops until
// the packet leaves, so nothing is lost.
// Reset clears running status, the partial message and both valid flags.
module serial_midi_to_usb_midi_packetizer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  logic [7:0] serial_byte,
    output logic       packet_valid,
    input  logic       packet_ready,
    output logic [3:0] code_index,
    output logic [7:0] first_data,
    output logic [7:0] second_data,
    output logic [7:0] third_data
);
    import smp_pkg::*;

    byte_item_t item;
    pkt_item_t  result;
    logic       take;
    logic       out_space;

    // Hold the received byte until the parser takes it.
    smp_in_reg u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .serial_byte (serial_byte),
        .take        (take),
        .item        (item)
    );

    // Decode the byte, advance running status, and build the packet.
    smp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .out_space (out_space),
        .take      (take),
        .result    (result)
    );

    // Hold the finished packet until the receiver takes it.
    smp_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .result       (result),
        .out_space    (out_space),
        .packet_valid (packet_valid),
        .packet_ready (packet_ready),
        .code_index   (code_index),
        .first_data   (first_data),
        .second_data  (second_data),
        .third_data   (third_data)
    );

endmodule

// File: sv/smp_checker.sv
// Port-level assertions on event packets of the MIDI packetizer, with bind.
`include "assert_macros.svh"

module smp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       packet_valid,
    input logic       packet_ready,
    input logic [3:0] code_index,
    input logic [7:0] first_data,
    input logic [7:0] second_data,
    input logic [7:0] third_data
);
    import smp_pkg::*;

    pkt_t pkt;
    logic cin_known;
    logic is_single;
    logic pads_ok;
    logic is_end;
    logic end_ok;
    logic is_channel;
    logic channel_ok;

    assign pkt        = {code_index, first_data, second_data, third_data};
    assign cin_known  = code_index >= CIN_COMMON_TWO && code_index <= CIN_CHANNEL_HIGH;
    assign is_single  = packet_valid && code_index == CIN_SINGLE;
    assign pads_ok    = first_data[7] && second_data == 8'h00 && third_data == 8'h00;
    assign is_end     = packet_valid
                        && (code_index == CIN_END_TWO || code_index == CIN_END_THREE);
    assign end_ok     = (code_index == CIN_END_TWO)
                        ? (second_data == SYSEX_END && third_data == 8'h00)
                        : (third_data == SYSEX_END);
    assign is_channel = packet_valid && code_index >= CIN_CHANNEL_LOW;
    assign channel_ok = first_data[7:4] == code_index && !second_data[7] && !third_data[7];

    `ASSERT_NEXT(a_stall_holds, packet_valid && !packet_ready, packet_valid && $stable(pkt))

    `ASSERT_HOLDS(a_cin_known, packet_valid, cin_known)

    `ASSERT_HOLDS(a_single_pads, is_single, pads_ok)

    `ASSERT_HOLDS(a_end_marks, is_end, end_ok)

    `ASSERT_HOLDS(a_channel_status, is_channel, channel_ok)

endmodule

bind serial_midi_to_usb_midi_packetizer smp_checker u_smp_checker (.*);
